/* rtl/core/pbc_pkg.sv */
// Shared types and constants for the PID biquad controller core.
// Holds field widths and configuration register indexes; depends on nothing.
package pbc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = 17;
    localparam int DRIVE_W    = 14;
    localparam int COEF_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEF_OUT1  = 3'd0,
        REG_COEF_OUT2  = 3'd1,
        REG_COEF_ERR0  = 3'd2,
        REG_COEF_ERR1  = 3'd3,
        REG_COEF_ERR2  = 3'd4,
        REG_FF_GAIN    = 3'd5,
        REG_ACTIVE     = 3'd6
    } cfg_index_t;

endpackage

/* rtl/core/pid_biquad_controller_core.sv */
// Top level of the PID biquad controller: configuration registers, history
// registers, the single-pass sum of products and the output register.
// Depends on pbc_pkg.

// Usage
// The slave stream carries one word per sample: target in s_tdata[15:0] and
// measured in s_tdata[31:16], both signed with SAMPLE_FRAC_BITS fraction bits.
// The master stream returns one word per sample: the saturated drive in
// m_tdata[13:0], upper bits zero.
// Coefficients and the active flag are written through cfg_we, cfg_addr and
// cfg_wdata while the block is idle; an index beyond the list is ignored.
// A word accepted at a clock edge is held in the input register, then passes
// through the sum of products into the output register once that register
// is free, and is offered on the master side from then on. A new word is
// taken in every cycle while the receiver keeps up, so throughput is one
// word per cycle. The figure is set by the recurrence through the
// previous output: the five products, their sum, the rounding and the
// saturation all sit in the combinational path between the input register
// and the history registers.
// When the receiver stalls, the output register holds its word while the
// input register takes one more; s_tready falls only once both are full.
// Reset clears all coefficients, the active flag, both error and output
// histories and the valid flags of both registers.
module pid_biquad_controller_core #(
    parameter int SAMPLE_FRAC_BITS = 12,
    parameter int COEF_FRAC_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [pbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Sample stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields, lowest bit up: target [15:0], measured [31:16]
    input  logic [pbc_pkg::IN_DATA_W-1:0]     s_tdata,
    // Drive stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields, lowest bit up: drive [13:0], zero fill [15:14]
    output logic [pbc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import pbc_pkg::*;

    // Width of a stored output value: it must hold plus and minus one.
    localparam int U_W      = SAMPLE_FRAC_BITS + 2;
    localparam int HIST_W   = (U_W > ERR_W) ? U_W : ERR_W;
    // Products plus enough guard bits for the five-term sum and the half LSB.
    localparam int ACC_W    = COEF_W + HIST_W + 4;
    localparam int FF_W     = COEF_W + SAMPLE_W;
    localparam int SHIFT_W  = U_W + COEF_FRAC_BITS;
    localparam int DRV_ACC_W = ((SHIFT_W > FF_W) ? SHIFT_W : FF_W) + 3;

    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_ONE =
        {{(ACC_W-1){1'b0}}, 1'b1} << SAMPLE_FRAC_BITS;
    localparam logic signed [DRV_ACC_W-1:0] DRV_HALF =
        {{(DRV_ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [DRV_ACC_W-1:0] DRV_ONE =
        {{(DRV_ACC_W-1){1'b0}}, 1'b1} << SAMPLE_FRAC_BITS;
    localparam logic signed [U_W-1:0] U_ONE =
        {{(U_W-1){1'b0}}, 1'b1} << SAMPLE_FRAC_BITS;

    // Configuration registers
    logic signed [COEF_W-1:0] coef_out1_reg;
    logic signed [COEF_W-1:0] coef_out2_reg;
    logic signed [COEF_W-1:0] coef_err0_reg;
    logic signed [COEF_W-1:0] coef_err1_reg;
    logic signed [COEF_W-1:0] coef_err2_reg;
    logic signed [COEF_W-1:0] ff_gain_reg;
    logic                     active_reg;

    // History registers
    logic signed [ERR_W-1:0] err_last_reg;
    logic signed [ERR_W-1:0] err_before_reg;
    logic signed [U_W-1:0]   out_last_reg;
    logic signed [U_W-1:0]   out_before_reg;

    // Input register
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic signed [SAMPLE_W-1:0] target_reg;
    logic signed [SAMPLE_W-1:0] measured_reg;

    // Output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [DRIVE_W-1:0]  drive_reg;
    logic signed [DRIVE_W-1:0]  drive_next;

    logic advance;
    logic in_take;

    // Datapath signals
    logic signed [ERR_W-1:0]         err;
    logic signed [COEF_W+U_W-1:0]    p_out1;
    logic signed [COEF_W+U_W-1:0]    p_out2;
    logic signed [COEF_W+ERR_W-1:0]  p_err0;
    logic signed [COEF_W+ERR_W-1:0]  p_err1;
    logic signed [COEF_W+ERR_W-1:0]  p_err2;
    logic signed [FF_W-1:0]          p_ff;
    logic signed [ACC_W-1:0]         acc_sum;
    logic signed [ACC_W-1:0]         acc_rnd;
    logic signed [U_W-1:0]           u_sat;
    logic signed [U_W-1:0]           u_next;
    logic signed [DRV_ACC_W-1:0]     drv_sum;
    logic signed [DRV_ACC_W-1:0]     drv_rnd;
    logic signed [U_W-1:0]           drv_sat;

    // ------------------------------------------------------------------
    // Handshake: the input register moves on whenever the output register
    // is empty or its word is being taken in the same cycle.
    // ------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-DRIVE_W){1'b0}}, drive_reg};

    // ------------------------------------------------------------------
    // Sum of products for the control value. All five products are formed
    // side by side and added in one tree.
    // ------------------------------------------------------------------
    assign err    = ERR_W'(target_reg) - ERR_W'(measured_reg);
    assign p_out1 = coef_out1_reg * out_last_reg;
    assign p_out2 = coef_out2_reg * out_before_reg;
    assign p_err0 = coef_err0_reg * err;
    assign p_err1 = coef_err1_reg * err_last_reg;
    assign p_err2 = coef_err2_reg * err_before_reg;
    assign p_ff   = ff_gain_reg * target_reg;

    assign acc_sum = ACC_W'(p_out1) + ACC_W'(p_out2) + ACC_W'(p_err0)
                   + ACC_W'(p_err1) + ACC_W'(p_err2);
    // Round to nearest with ties upward: add half an LSB, then floor.
    assign acc_rnd = (acc_sum + ACC_HALF) >>> COEF_FRAC_BITS;

    always_comb
    begin
        priority if (acc_rnd >= ACC_ONE)
        begin
            u_sat = U_ONE;
        end
        else if (acc_rnd <= -ACC_ONE)
        begin
            u_sat = -U_ONE;
        end
        else
        begin
            u_sat = acc_rnd[U_W-1:0];
        end
    end

    // An inactive controller stores zero as its output.
    assign u_next = active_reg ? u_sat : '0;

    // Drive: the control value at coefficient scale plus the feedforward
    // term, rounded and saturated once more.
    assign drv_sum = (DRV_ACC_W'(u_next) <<< COEF_FRAC_BITS) + DRV_ACC_W'(p_ff) + DRV_HALF;
    assign drv_rnd = drv_sum >>> COEF_FRAC_BITS;

    always_comb
    begin
        priority if (drv_rnd >= DRV_ONE)
        begin
            drv_sat = U_ONE;
        end
        else if (drv_rnd <= -DRV_ONE)
        begin
            drv_sat = -U_ONE;
        end
        else
        begin
            drv_sat = drv_rnd[U_W-1:0];
        end
    end

    // Drive is zero when inactive or when the target is exactly zero; a wide
    // sample format keeps only the low bits of the saturated value.
    assign drive_next = (active_reg && (target_reg != '0)) ? DRIVE_W'(drv_sat) : '0;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_out1_reg <= '0;
            coef_out2_reg <= '0;
            coef_err0_reg <= '0;
            coef_err1_reg <= '0;
            coef_err2_reg <= '0;
            ff_gain_reg   <= '0;
            active_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_COEF_OUT1: coef_out1_reg <= cfg_wdata;
                REG_COEF_OUT2: coef_out2_reg <= cfg_wdata;
                REG_COEF_ERR0: coef_err0_reg <= cfg_wdata;
                REG_COEF_ERR1: coef_err1_reg <= cfg_wdata;
                REG_COEF_ERR2: coef_err2_reg <= cfg_wdata;
                REG_FF_GAIN:   ff_gain_reg   <= cfg_wdata;
                REG_ACTIVE:    active_reg    <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state: valid flags and the two histories, which shift with
    // every word that leaves the input register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            err_last_reg   <= '0;
            err_before_reg <= '0;
            out_last_reg   <= '0;
            out_before_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                err_before_reg <= err_last_reg;
                err_last_reg   <= err;
                out_before_reg <= out_last_reg;
                out_last_reg   <= u_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            target_reg   <= s_tdata[SAMPLE_W-1:0];
            measured_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (advance)
        begin
            drive_reg <= drive_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input refused while output register empty");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !active_reg) |=> (drive_reg == '0) && (out_last_reg == '0))
        else $error("inactive controller produced non-zero drive or output");

    a_err_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (err_before_reg == $past(err_last_reg)))
        else $error("error history did not shift");

    a_hold_history: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(out_last_reg) && $stable(err_last_reg))
        else $error("history changed without a word moving on");

endmodule
